### sv/fpss_pkg.sv
// ----------------------------------------------------------------------------
// fpss_pkg
// Shared types and constants for the fractional PLL setting sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpss_pkg;

  // default parameter values
  localparam int NUM_BANKS_DEF         = 4;
  localparam int CLK_CONTROL_REG_DEF   = 16;
  localparam int PLL_A_FIRST_REG_DEF   = 26;
  localparam int PLL_RESET_REG_DEF     = 177;
  localparam int OUTPUT_ENABLE_REG_DEF = 3;

  // arithmetic constants
  localparam logic [29:0] PLL_MAX_HZ = 30'd900000000;
  localparam logic [19:0] FRAC_DENOM = 20'hFFFFF;
  localparam logic [17:0] P1_OFFSET  = 18'd512;

  // register data codes
  localparam logic [7:0] CLK_OFF_DATA     = 8'h84;
  localparam logic [7:0] PLL_RESET_DATA   = 8'hA0;
  localparam logic [7:0] CLK_ON_DATA      = 8'h4F;
  localparam logic [7:0] OUT_CLK0_DATA    = 8'hFE;
  localparam logic [7:0] OUT_ALL_OFF_DATA = 8'hFF;

  // configuration register indexes
  localparam logic [0:0] CFG_XTAL_HZ     = 1'b0;
  localparam logic [0:0] CFG_DEVICE_ADDR = 1'b1;
  localparam logic [25:0] XTAL_RESET     = 26'd25000000;
  localparam logic [6:0]  DEV_ADDR_RESET = 7'd96;

  // update run positions
  localparam logic [3:0] EMIT_CLK_OFF    = 4'd0;
  localparam logic [3:0] EMIT_LAST_BYTE  = 4'd8;
  localparam logic [3:0] EMIT_PLL_RESET  = 4'd9;
  localparam logic [3:0] EMIT_CLK_ON     = 4'd10;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;

  // divider widths
  localparam int DIV_N_W = 46;
  localparam int DIV_D_W = 30;
  localparam int DIV_C_W = 6;

  typedef enum logic [1:0] {
    OP_SET_FREQ   = 2'd0,
    OP_UPDATE     = 2'd1,
    OP_OUT_ENABLE = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t     kind;
    logic [29:0] freq;
    logic [1:0]  bank;
    logic        bank_ok;
    logic        enable;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
    logic [DIV_C_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_MUL,
    ST_DIV_XTAL,
    ST_DIV_NUM,
    ST_FRAC,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

### sv/fpss_front.sv
// ----------------------------------------------------------------------------
// fpss_front
// Accepts command requests, drops ones that do nothing, holds one for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_front
  import fpss_pkg::*;
#(
  parameter int NUM_BANKS = NUM_BANKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [29:0] freq_hz,
  input  wire logic [1:0]  bank,
  input  wire logic        enable,
  input  wire logic        q_full,
  output logic             push,
  output cmd_t             push_cmd
);

  logic slot_valid;
  cmd_t slot;
  logic accept;
  logic bank_ok;
  logic keep;

  // classify the incoming request
  assign accept  = start && !busy;
  assign bank_ok = 32'(bank) < NUM_BANKS;
  always_comb begin
    case (opcode)
      OP_SET_FREQ:   keep = bank_ok;
      OP_UPDATE:     keep = 1'b1;
      OP_OUT_ENABLE: keep = 1'b1;
      default:       keep = 1'b0;
    endcase
  end

  // hold slot
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (push) begin
      slot_valid <= 1'b0;
    end else if (accept && keep) begin
      slot_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot.kind    <= opcode_t'(opcode);
      slot.freq    <= freq_hz;
      slot.bank    <= bank;
      slot.bank_ok <= bank_ok;
      slot.enable  <= enable;
    end
  end

  assign busy     = slot_valid;
  assign push     = slot_valid && !q_full;
  assign push_cmd = slot;

endmodule

`default_nettype wire

### sv/fpss_queue.sv
// ----------------------------------------------------------------------------
// fpss_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_queue
  import fpss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      din,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty,
  output logic      full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign dout  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### sv/fpss_div.sv
// ----------------------------------------------------------------------------
// fpss_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_div
  import fpss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic               busy;
  logic               done;
  logic [DIV_C_W-1:0] cnt;
  logic [DIV_N_W-1:0] q;
  logic [DIV_D_W-1:0] r;
  logic [DIV_D_W-1:0] d;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  // one trial subtract per cycle
  assign trial = {r, q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, d};
  assign ge    = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_C_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      cnt <= req.nbits;
      q   <= req.dividend;
      r   <= '0;
      d   <= req.divisor;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      q   <= {q[DIV_N_W-2:0], ge};
      r   <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

`default_nettype wire

### sv/fpss_back.sv
// ----------------------------------------------------------------------------
// fpss_back
// Runs queued commands: multiplier arithmetic into banks, write runs out.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_back
  import fpss_pkg::*;
#(
  parameter int NUM_BANKS         = NUM_BANKS_DEF,
  parameter int CLK_CONTROL_REG   = CLK_CONTROL_REG_DEF,
  parameter int PLL_A_FIRST_REG   = PLL_A_FIRST_REG_DEF,
  parameter int PLL_RESET_REG     = PLL_RESET_REG_DEF,
  parameter int OUTPUT_ENABLE_REG = OUTPUT_ENABLE_REG_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  cmd_t             head,
  output logic             pop,
  input  wire logic [25:0] xtal_hz,
  input  wire logic [6:0]  device_address,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             write_strobe,
  output logic [6:0]       bus_address,
  output logic [7:0]       reg_address,
  output logic [7:0]       reg_byte,
  output logic             last
);

  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [29:0] divider;
  logic [31:0] pll;
  logic [7:0]  mult;
  logic [25:0] rem_x;
  logic [19:0] num;
  logic [3:0]  emit_cnt;
  logic [63:0] row_sh;

  logic [63:0] rows [NUM_BANKS];
  logic [NUM_BANKS-1:0] row_valid;

  logic [25:0]      xtal_eff;
  logic [3:0]       head_bank_ext;
  logic [3:0]       cur_bank_ext;
  logic [BANK_W-1:0] head_idx;
  logic [BANK_W-1:0] cur_idx;
  logic [45:0]      num_dividend;
  logic [6:0]       frac_hi;
  logic [20:0]      frac_sum;
  logic             frac_ge;
  logic [7:0]       frac_q;
  logic [20:0]      frac_rem;
  logic [17:0]      p1;
  logic [19:0]      p2;
  logic [63:0]      row_new;
  logic             div_done;

  logic       strobe_next;
  logic [7:0] wr_reg_next;
  logic [7:0] reg_byte_next;
  logic       last_next;

  assign xtal_eff      = (xtal_hz == '0) ? 26'd1 : xtal_hz;
  assign head_bank_ext = {2'b00, head.bank};
  assign cur_bank_ext  = {2'b00, cur.bank};
  assign head_idx      = head_bank_ext[BANK_W-1:0];
  assign cur_idx       = cur_bank_ext[BANK_W-1:0];
  assign num_dividend  = {rem_x, 20'd0} - {20'd0, rem_x};
  assign div_done      = div_rsp.done;

  // 128*num split by 2^20-1: hi*2^20 + lo = hi*(2^20-1) + (hi + lo)
  assign frac_hi  = num[19:13];
  assign frac_sum = {1'b0, num[12:0], 7'd0} + {14'd0, frac_hi};
  assign frac_ge  = frac_sum >= {1'b0, FRAC_DENOM};
  assign frac_q   = {1'b0, frac_hi} + {7'd0, frac_ge};
  assign frac_rem = frac_ge ? (frac_sum - {1'b0, FRAC_DENOM}) : frac_sum;

  // P1, P2 from the fraction split
  assign p1 = {3'd0, mult, 7'd0} + {10'd0, frac_q} - P1_OFFSET;
  assign p2 = frac_rem[19:0];
  assign row_new = {FRAC_DENOM[15:8], FRAC_DENOM[7:0], 6'd0, p1[17:16], p1[15:8],
                    p1[7:0], FRAC_DENOM[19:16], p2[19:16], p2[15:8], p2[7:0]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            OP_SET_FREQ: state_next = (head.freq == '0) ? ST_DIV_XTAL : ST_DIV_FREQ;
            OP_UPDATE:   state_next = ST_EMIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV_FREQ: if (div_done) state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIV_XTAL;
      ST_DIV_XTAL: if (div_done) state_next = ST_DIV_NUM;
      ST_DIV_NUM:  if (div_done) state_next = ST_FRAC;
      ST_FRAC:     state_next = ST_IDLE;
      ST_EMIT:     if (emit_cnt == EMIT_CLK_ON) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs: pop, divider request, next write
  always_comb begin
    pop              = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.nbits    = '0;
    strobe_next      = 1'b0;
    wr_reg_next      = '0;
    reg_byte_next    = '0;
    last_next        = 1'b0;
    case (state)
      ST_IDLE: begin
        pop = !q_empty;
        if (!q_empty && head.kind == OP_OUT_ENABLE) begin
          strobe_next   = 1'b1;
          wr_reg_next   = 8'(OUTPUT_ENABLE_REG);
          reg_byte_next = head.enable ? OUT_CLK0_DATA : OUT_ALL_OFF_DATA;
          last_next     = 1'b1;
        end
      end
      ST_DIV_FREQ: begin
        div_req.start    = !div_rsp.busy && !div_rsp.done;
        div_req.dividend = {PLL_MAX_HZ, 16'd0};
        div_req.divisor  = cur.freq;
        div_req.nbits    = DIV_C_W'(30);
      end
      ST_DIV_XTAL: begin
        div_req.start    = !div_rsp.busy && !div_rsp.done;
        div_req.dividend = {pll, 14'd0};
        div_req.divisor  = {4'd0, xtal_eff};
        div_req.nbits    = DIV_C_W'(32);
      end
      ST_DIV_NUM: begin
        div_req.start    = !div_rsp.busy && !div_rsp.done;
        div_req.dividend = num_dividend;
        div_req.divisor  = {4'd0, xtal_eff};
        div_req.nbits    = DIV_C_W'(46);
      end
      ST_EMIT: begin
        strobe_next = 1'b1;
        if (emit_cnt == EMIT_CLK_OFF) begin
          wr_reg_next   = 8'(CLK_CONTROL_REG);
          reg_byte_next = CLK_OFF_DATA;
        end else if (emit_cnt <= EMIT_LAST_BYTE) begin
          wr_reg_next   = 8'(PLL_A_FIRST_REG) + {5'd0, 3'(emit_cnt - 4'd1)};
          reg_byte_next = row_sh[63:56];
        end else if (emit_cnt == EMIT_PLL_RESET) begin
          wr_reg_next   = 8'(PLL_RESET_REG);
          reg_byte_next = PLL_RESET_DATA;
        end else begin
          wr_reg_next   = 8'(CLK_CONTROL_REG);
          reg_byte_next = CLK_ON_DATA;
          last_next     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state and write strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_strobe <= 1'b0;
    end else begin
      state        <= state_next;
      write_strobe <= strobe_next;
    end
  end

  // write payload
  always_ff @(posedge clk) begin
    bus_address <= device_address;
    reg_address <= wr_reg_next;
    reg_byte    <= reg_byte_next;
    last        <= last_next;
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head;
      pll      <= '0;
      emit_cnt <= '0;
    end
    case (state)
      ST_DIV_FREQ: if (div_done) divider <= {div_rsp.quot[29:1], 1'b0};
      ST_MUL:      pll <= 32'(divider * cur.freq);
      ST_DIV_XTAL: begin
        if (div_done) begin
          mult  <= div_rsp.quot[7:0];
          rem_x <= div_rsp.rem[25:0];
        end
      end
      ST_DIV_NUM:  if (div_done) num <= div_rsp.quot[19:0];
      ST_EMIT:     emit_cnt <= emit_cnt + 1'b1;
      default: ;
    endcase
  end

  // bank row read and byte shift for update runs
  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_UPDATE) begin
      row_sh <= (head.bank_ok && row_valid[head_idx]) ? rows[head_idx] : '0;
    end else if (state == ST_EMIT && emit_cnt != EMIT_CLK_OFF) begin
      row_sh <= {row_sh[55:0], 8'd0};
    end
  end

  // bank store
  always_ff @(posedge clk) begin
    if (state == ST_FRAC && cur.bank_ok) begin
      rows[cur_idx] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (state == ST_FRAC && cur.bank_ok) begin
      row_valid[cur_idx] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### sv/fractional_pll_setting_sequencer.sv
// ----------------------------------------------------------------------------
// fractional_pll_setting_sequencer
// Command sequencer computing fractional PLL settings and register writes.
// ----------------------------------------------------------------------------
// Set-frequency spends most of its back-end time in serial division
//   (30+32+46 bits in one shared divider); update gives 11 writes on consecutive
//   cycles, and output-enable gives a single write. The back end runs one request
//   at a time; two more wait in the queue and one in the front slot. Reset:
//   synchronous; banks read as zero, crystal 25 MHz, address 96. Writes cannot
//   be stalled.
`default_nettype none

module fractional_pll_setting_sequencer
  import fpss_pkg::*;
#(
  parameter int NUM_BANKS         = NUM_BANKS_DEF,
  parameter int CLK_CONTROL_REG   = CLK_CONTROL_REG_DEF,
  parameter int PLL_A_FIRST_REG   = PLL_A_FIRST_REG_DEF,
  parameter int PLL_RESET_REG     = PLL_RESET_REG_DEF,
  parameter int OUTPUT_ENABLE_REG = OUTPUT_ENABLE_REG_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [29:0] freq_hz,
  input  wire logic [1:0]  bank,
  input  wire logic        enable,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [25:0] cfg_data,
  output logic             write_strobe,
  output logic [6:0]       bus_address,
  output logic [7:0]       reg_address,
  output logic [7:0]       reg_byte,
  output logic             last
);

  logic        xtal_hz_reg_unused;
  logic [25:0] xtal_hz;
  logic [6:0]  device_address;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign xtal_hz_reg_unused = 1'b0;
  assign cfg_ready = !xtal_hz_reg_unused;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      xtal_hz        <= XTAL_RESET;
      device_address <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_XTAL_HZ:     xtal_hz        <= cfg_data;
        CFG_DEVICE_ADDR: device_address <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  fpss_front #(
    .NUM_BANKS(NUM_BANKS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .freq_hz  (freq_hz),
    .bank     (bank),
    .enable   (enable),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  fpss_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  fpss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fpss_back #(
    .NUM_BANKS        (NUM_BANKS),
    .CLK_CONTROL_REG  (CLK_CONTROL_REG),
    .PLL_A_FIRST_REG  (PLL_A_FIRST_REG),
    .PLL_RESET_REG    (PLL_RESET_REG),
    .OUTPUT_ENABLE_REG(OUTPUT_ENABLE_REG)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .xtal_hz        (xtal_hz),
    .device_address (device_address),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .write_strobe   (write_strobe),
    .bus_address    (bus_address),
    .reg_address    (reg_address),
    .reg_byte       (reg_byte),
    .last           (last)
  );

endmodule

`default_nettype wire

### sv/fpss_checker.sv
// ----------------------------------------------------------------------------
// fpss_checker
// Port-level checks on the sequencer's request and write behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic write_strobe,
  input wire logic last
);

  // no write right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !write_strobe)
    else $error("write strobe right after reset");

  // an update run has no gaps until its last write
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (write_strobe && !last) |=> write_strobe)
    else $error("gap inside a write run");

  // busy only rises after a request
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind fractional_pll_setting_sequencer fpss_checker u_fpss_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .write_strobe (write_strobe),
  .last         (last)
);

`default_nettype wire

### tb/fractional_pll_setting_sequencer_tb.sv
// ----------------------------------------------------------------------------
// fractional_pll_setting_sequencer_tb
// Self-checking bench: drives set-frequency, update and output-enable
// requests, predicts every register write in software and compares each one.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_pll_setting_sequencer_tb;
  import fpss_pkg::*;

  localparam int NB = 4;

  typedef struct packed {
    logic [6:0] bus_addr;
    logic [7:0] dest_reg;
    logic [7:0] data;
    logic       fin;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [29:0] freq_hz = '0;
  logic [1:0]  bank = '0;
  logic        enable = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;
  logic        write_strobe;
  logic [6:0]  bus_address;
  logic [7:0]  reg_address;
  logic [7:0]  reg_byte;
  logic        last;

  // predictor state
  logic [7:0]  pll_bytes [NB*8];
  logic [25:0] xtal_reg;
  logic [6:0]  dev_addr;
  reg_write_t  pending_writes [$];
  int          mismatches = 0;
  int          writes_seen = 0;
  int          requests_sent = 0;

  fractional_pll_setting_sequencer DUT (
    .clk, .rst, .start, .busy, .opcode, .freq_hz, .bank, .enable,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .write_strobe, .bus_address, .reg_address, .reg_byte, .last
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d writes still pending", pending_writes.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic void push_write(logic [7:0] ra, logic [7:0] d, logic f);
    reg_write_t w;
    w.bus_addr = dev_addr;
    w.dest_reg = ra;
    w.data     = d;
    w.fin      = f;
    pending_writes.push_back(w);
  endfunction

  // multisynth parameter computation into a bank
  function automatic void compute_pll_bank(logic [29:0] f, logic [1:0] b);
    logic [31:0] xt, dv, pll, mult, rem, num, scaled, p1, p2;
    logic [63:0] wide;
    xt = (xtal_reg == 0) ? 32'd1 : {6'd0, xtal_reg};
    dv = (f == 0) ? 32'd0 : 32'(PLL_MAX_HZ) / {2'd0, f};
    dv[0] = 1'b0;
    pll    = dv * {2'd0, f};
    mult   = (pll / xt) & 32'hFF;
    rem    = pll % xt;
    wide   = (64'(rem) * 64'(FRAC_DENOM)) / 64'(xt);
    num    = wide[31:0];
    scaled = 32'd128 * num;
    p1     = 32'd128 * mult + scaled / 32'(FRAC_DENOM) - 32'd512;
    p2     = scaled % 32'(FRAC_DENOM);
    pll_bytes[b*8+0] = FRAC_DENOM[15:8];
    pll_bytes[b*8+1] = FRAC_DENOM[7:0];
    pll_bytes[b*8+2] = {6'd0, p1[17:16]};
    pll_bytes[b*8+3] = p1[15:8];
    pll_bytes[b*8+4] = p1[7:0];
    pll_bytes[b*8+5] = {FRAC_DENOM[19:16], p2[19:16]};
    pll_bytes[b*8+6] = p2[15:8];
    pll_bytes[b*8+7] = p2[7:0];
  endfunction

  function automatic void predict_writes(logic [1:0] op, logic [29:0] f, logic [1:0] b,
                                         logic en);
    case (op)
      OP_SET_FREQ: begin
        compute_pll_bank(f, b);
      end
      OP_UPDATE: begin
        push_write(8'(CLK_CONTROL_REG_DEF), CLK_OFF_DATA, 1'b0);
        for (int i = 0; i < 8; i++) begin
          push_write(8'(PLL_A_FIRST_REG_DEF + i), pll_bytes[b*8+i], 1'b0);
        end
        push_write(8'(PLL_RESET_REG_DEF), PLL_RESET_DATA, 1'b0);
        push_write(8'(CLK_CONTROL_REG_DEF), CLK_ON_DATA, 1'b1);
      end
      OP_OUT_ENABLE: begin
        push_write(8'(OUTPUT_ENABLE_REG_DEF), en ? OUT_CLK0_DATA : OUT_ALL_OFF_DATA, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  // write checker
  always @(posedge clk) begin
    reg_write_t want;
    if (!rst && write_strobe) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write reg", 32'(reg_address), 32'hFFFF_FFFF);
      end else begin
        want = pending_writes.pop_front();
        if (bus_address !== want.bus_addr)
          report_mismatch("bus_address", 32'(bus_address), 32'(want.bus_addr));
        if (reg_address !== want.dest_reg)
          report_mismatch("reg_address", 32'(reg_address), 32'(want.dest_reg));
        if (reg_byte !== want.data)
          report_mismatch("reg_byte", 32'(reg_byte), 32'(want.data));
        if (last !== want.fin)
          report_mismatch("last", 32'(last), 32'(want.fin));
      end
    end
  end

  function automatic int random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // one command request; holds start until accepted, keeps it up for a
  // request that follows with no gap
  task automatic send_cmd(logic [1:0] op, logic [29:0] f, logic [1:0] b, logic en);
    int n;
    start   <= 1'b1;
    opcode  <= op;
    freq_hz <= f;
    bank    <= b;
    enable  <= en;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_writes(op, f, b, en);
    requests_sent++;
    n = random_gap();
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drain: wait for all writes, then long enough for a full queue of set-frequency
  // requests to finish
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [25:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_XTAL_HZ) xtal_reg = val;
    else dev_addr = val[6:0];
    @(posedge clk);
  endtask

  function automatic logic [29:0] pick_freq();
    case ($urandom_range(0, 7))
      0: return 30'($urandom_range(0, 20));
      1: return 30'($urandom_range(899_000_000, 1_073_741_823));
      2: return 30'($urandom);
      default: return 30'($urandom_range(1_000_000, 200_000_000));
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(OP_UPDATE, 30'd0, 2'd0, 1'b0);
    send_cmd(OP_OUT_ENABLE, 30'd0, 2'd0, 1'b1);
    send_cmd(OP_OUT_ENABLE, 30'h3FFF_FFFF, 2'd3, 1'b0);
    send_cmd(OP_SET_FREQ, 30'd10_000_000, 2'd0, 1'b0);
    send_cmd(OP_SET_FREQ, 30'd0, 2'd1, 1'b1);
    send_cmd(OP_SET_FREQ, 30'h3FFF_FFFF, 2'd2, 1'b0);
    send_cmd(OP_SET_FREQ, 30'd1, 2'd3, 1'b0);
    send_cmd(2'd3, 30'h2AAA_AAAA, 2'd1, 1'b1);
    for (int b = 0; b < NB; b++) send_cmd(OP_UPDATE, 30'd0, 2'(b), 1'b0);
    send_cmd(OP_SET_FREQ, 30'd900_000_000, 2'd0, 1'b0);
    send_cmd(OP_SET_FREQ, 30'd7_100_000, 2'd1, 1'b1);
    send_cmd(OP_UPDATE, 30'd0, 2'd0, 1'b1);
    send_cmd(OP_UPDATE, 30'd0, 2'd1, 1'b0);
  endtask

  task automatic test_crystal_extremes();
    write_cfg(CFG_XTAL_HZ, 26'd0);
    write_cfg(CFG_DEVICE_ADDR, 26'd0);
    send_cmd(OP_SET_FREQ, 30'd14_000_000, 2'd2, 1'b0);
    send_cmd(OP_UPDATE, 30'd0, 2'd2, 1'b0);
    write_cfg(CFG_XTAL_HZ, 26'h3FF_FFFF);
    write_cfg(CFG_DEVICE_ADDR, 26'h3FF_FFFF);
    send_cmd(OP_SET_FREQ, 30'd3_000_000, 2'd3, 1'b1);
    send_cmd(OP_UPDATE, 30'd0, 2'd3, 1'b1);
    write_cfg(CFG_XTAL_HZ, 26'd1);
    send_cmd(OP_SET_FREQ, 30'd50_000_000, 2'd0, 1'b0);
    send_cmd(OP_UPDATE, 30'd0, 2'd0, 1'b0);
  endtask

  // mostly set-then-update pairs with random content, some noise
  task automatic test_random(int n, int sets_per_phase);
    logic [1:0] b;
    for (int i = 0; i < n; i++) begin
      if (i % sets_per_phase == sets_per_phase - 1) begin
        write_cfg(CFG_XTAL_HZ, 26'($urandom_range(0, 67_108_863)));
        write_cfg(CFG_DEVICE_ADDR, 26'($urandom));
      end
      b = 2'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_cmd(OP_SET_FREQ, pick_freq(), b, 1'($urandom));
          send_cmd(OP_UPDATE, 30'($urandom), b, 1'($urandom));
          i++;
        end
        4, 5: send_cmd(OP_UPDATE, 30'($urandom), b, 1'($urandom));
        6: send_cmd(OP_SET_FREQ, pick_freq(), b, 1'($urandom));
        7, 8: send_cmd(OP_OUT_ENABLE, 30'($urandom), b, 1'($urandom));
        default: send_cmd(2'd3, 30'($urandom), b, 1'($urandom));
      endcase
      if (i == n / 2) wait_idle();
    end
  endtask

  initial begin
    xtal_reg = XTAL_RESET;
    dev_addr = DEV_ADDR_RESET;
    foreach (pll_bytes[i]) pll_bytes[i] = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_crystal_extremes();
    write_cfg(CFG_XTAL_HZ, 26'd25_000_000);
    write_cfg(CFG_DEVICE_ADDR, 26'd96);
    test_random(420, 60);

    wait_idle();
    $display("Covered %0d requests (set, update, enable, unused) over several crystal",
             requests_sent);
    $display("and address settings; %0d register writes checked.", writes_seen);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
